### rtl/grsp_pkg.sv
`timescale 1ns / 1ps

package grsp_pkg;

    // width of one occupancy word and of a bit index inside it
    localparam int OCC_BITS  = 64;
    localparam int OCC_BIT_W = 6;

    typedef enum logic [1:0] {
        REQ_ADD        = 2'd0,
        REQ_LOOKUP     = 2'd1,
        REQ_RELEASE    = 2'd2,
        REQ_TRANSITION = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_NULL_TAG = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type   req_type;
        logic [8:0]  handle_slot;
        logic [31:0] handle_generation;
        logic [63:0] object_tag;
        logic [31:0] state_value;
        logic [7:0]  format_code;
        logic [15:0] remaining_refs;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [8:0]  out_slot;
        logic [31:0] out_generation;
        logic [63:0] out_tag;
        logic [31:0] state_before;
        logic [31:0] state_after;
        logic [7:0]  out_format;
        logic        barrier_needed;
        logic        slot_freed;
    } t_rsp;

    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] state;
        logic [7:0]  format;
        logic [31:0] generation;
    } t_entry;

endpackage

### rtl/grsp_entry_mem.sv
`timescale 1ns / 1ps

// slot table: one write port, one registered read port
module grsp_entry_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output grsp_pkg::t_entry      o_rd_data,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  grsp_pkg::t_entry      i_wr_data
);

    grsp_pkg::t_entry mem [DEPTH];
    grsp_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/grsp_occ_map.sv
`timescale 1ns / 1ps

// occupancy bitmap in words, with one full flag per word for the free search
module grsp_occ_map #(
    parameter int NUM_SLOTS = 256,
    parameter int NUM_WORDS = 4,
    parameter int WORD_W    = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [WORD_W-1:0]                  i_rd_addr,
    output logic [grsp_pkg::OCC_BITS-1:0]      o_rd_data,
    output logic [grsp_pkg::OCC_BIT_W-1:0]     o_free_bit,
    output logic [WORD_W-1:0]                  o_free_word,
    output logic                               o_pool_full,
    input  logic                               i_wr_en,
    input  logic [WORD_W-1:0]                  i_wr_addr,
    input  logic [grsp_pkg::OCC_BITS-1:0]      i_wr_data
);

    logic [grsp_pkg::OCC_BITS-1:0] mem [NUM_WORDS];
    logic [grsp_pkg::OCC_BITS-1:0] r_rd_data;
    logic [WORD_W-1:0]             r_rd_addr;
    logic [NUM_WORDS-1:0]          r_full;
    logic [grsp_pkg::OCC_BITS-1:0] rd_busy;

    // bits past the last slot count as taken
    function automatic logic [grsp_pkg::OCC_BITS-1:0] pad_mask(input logic [WORD_W-1:0] w);
        logic [grsp_pkg::OCC_BITS-1:0] m;
        int                            base;
        base = int'(w) * grsp_pkg::OCC_BITS;
        for (int b = 0; b < grsp_pkg::OCC_BITS; b++) begin
            m[b] = (base + b) >= NUM_SLOTS;
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_wr_en) begin
            r_full[i_wr_addr] <= &(i_wr_data | pad_mask(i_wr_addr));
        end
    end

    assign rd_busy = r_rd_data | pad_mask(r_rd_addr);

    // lowest clear bit of the word just read
    always_comb begin
        o_free_bit = '0;
        for (int b = grsp_pkg::OCC_BITS - 1; b >= 0; b--) begin
            if (!rd_busy[b]) begin
                o_free_bit = grsp_pkg::OCC_BIT_W'(b);
            end
        end
    end

    // lowest word that still has room
    always_comb begin
        o_free_word = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                o_free_word = WORD_W'(i);
            end
        end
    end

    assign o_pool_full = &r_full;
    assign o_rd_data   = r_rd_data;

endmodule

### rtl/generational_resource_slot_pool.sv
`timescale 1ns / 1ps

// generational handle pool of NUM_SLOTS slots numbered from 1. one request word
// is worked at a time. lookup, release, transition and a rejected add go from
// acceptance to the execute step, which registers their result and frees the
// input together. an add that gets a slot passes the find step on the way: it
// first reads the occupancy word picked by the per-word full flags, then reads
// the slot it found, then writes back. the limit is the read-modify-write of one
// slot table entry and one bitmap word. the result register lets the next request
// word in while a result waits; that word then holds in its execute step until
// the waiting result is taken. after reset a clearing pass over all NUM_SLOTS
// slots zeroes the slot table and bitmap; no request word is taken until it ends.
module generational_resource_slot_pool #(
    parameter int NUM_SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  grsp_pkg::t_req   i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output grsp_pkg::t_rsp   o_out_word
);

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_WORDS = (NUM_SLOTS + grsp_pkg::OCC_BITS - 1) / grsp_pkg::OCC_BITS;
    localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = WORD_W + grsp_pkg::OCC_BIT_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FIND  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    // control
    t_state                          r_state, n_state;
    logic [SLOT_W-1:0]               r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;

    // request held while it is worked
    grsp_pkg::t_req                  r_req;
    grsp_pkg::t_status               r_err, n_err;
    logic [SLOT_W-1:0]               r_idx;
    logic [grsp_pkg::OCC_BIT_W-1:0]  r_bit;
    logic [WORD_W-1:0]               r_word;
    grsp_pkg::t_rsp                  r_out;

    logic                            in_accept;
    logic                            is_add;
    logic                            slot_ok;
    logic [31:0]                     slot_ext;
    logic [31:0]                     find_ext;
    logic [31:0]                     slot_p1;
    logic                            exec_go;
    logic                            handle_ok;
    logic [grsp_pkg::OCC_BITS-1:0]   bit_mask;
    grsp_pkg::t_rsp                  rsp;

    // memory ports
    logic                            ent_rd_en;
    logic [SLOT_W-1:0]               ent_rd_addr;
    grsp_pkg::t_entry                ent_rd_data;
    logic                            ent_we;
    logic [SLOT_W-1:0]               ent_wr_addr;
    grsp_pkg::t_entry                ent_wd;

    logic                            occ_rd_en;
    logic [WORD_W-1:0]               occ_rd_addr;
    logic [grsp_pkg::OCC_BITS-1:0]   occ_rd_data;
    logic [grsp_pkg::OCC_BIT_W-1:0]  occ_free_bit;
    logic [WORD_W-1:0]               occ_free_word;
    logic                            pool_full;
    logic                            occ_we;
    logic [WORD_W-1:0]               occ_wr_addr;
    logic [grsp_pkg::OCC_BITS-1:0]   occ_wd;

    grsp_entry_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_entry_mem (
        .i_clk     (i_clk),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wd)
    );

    grsp_occ_map #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_WORDS (NUM_WORDS),
        .WORD_W    (WORD_W)
    ) u_occ_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (occ_rd_en),
        .i_rd_addr   (occ_rd_addr),
        .o_rd_data   (occ_rd_data),
        .o_free_bit  (occ_free_bit),
        .o_free_word (occ_free_word),
        .o_pool_full (pool_full),
        .i_wr_en     (occ_we),
        .i_wr_addr   (occ_wr_addr),
        .i_wr_data   (occ_wd)
    );

    // -------------------------------------------------------------------
    // acceptance and early checks
    // -------------------------------------------------------------------
    // only one word is in flight, and its write-back lands before
    // the next acceptance can read, so no forwarding path is needed
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign is_add     = (i_in_word.req_type == grsp_pkg::REQ_ADD);

    // handle slot 1..NUM_SLOTS maps to table index 0..NUM_SLOTS-1
    assign slot_ext = 32'(i_in_word.handle_slot) - 32'd1;
    assign slot_ok  = (i_in_word.handle_slot != 9'd0) &&
                      (32'(i_in_word.handle_slot) <= 32'(NUM_SLOTS));

    always_comb begin
        if (is_add) begin
            if (i_in_word.object_tag == 64'd0) begin
                n_err = grsp_pkg::ST_NULL_TAG;  // checked ahead of the free search
            end else if (pool_full) begin
                n_err = grsp_pkg::ST_FULL;
            end else begin
                n_err = grsp_pkg::ST_OK;
            end
        end else begin
            n_err = slot_ok ? grsp_pkg::ST_OK : grsp_pkg::ST_INVALID;
        end
    end

    // add reads the first word with room; other requests read the handle's word
    assign occ_rd_en   = in_accept && (n_err == grsp_pkg::ST_OK);
    assign occ_rd_addr = is_add ? occ_free_word : slot_ext[IDX_W-1:grsp_pkg::OCC_BIT_W];

    // add slot index: word number and lowest clear bit in it
    assign find_ext = 32'({r_word, occ_free_bit});

    assign ent_rd_en   = (in_accept && !is_add && (n_err == grsp_pkg::ST_OK)) ||
                         (r_state == S_FIND);
    assign ent_rd_addr = (r_state == S_FIND) ? find_ext[SLOT_W-1:0] : slot_ext[SLOT_W-1:0];

    // -------------------------------------------------------------------
    // execute: check the handle, build the result, write back
    // -------------------------------------------------------------------
    assign exec_go   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign bit_mask  = grsp_pkg::OCC_BITS'(1) << r_bit;
    assign slot_p1   = 32'(r_idx) + 32'd1;
    assign handle_ok = (r_req.handle_generation != 32'd0) &&
                       (r_req.handle_generation == ent_rd_data.generation) &&
                       (ent_rd_data.tag != 64'd0);

    logic                         exec_ent_we;
    grsp_pkg::t_entry             exec_ent_wd;
    logic                         exec_occ_we;
    logic [grsp_pkg::OCC_BITS-1:0] exec_occ_wd;

    always_comb begin
        rsp         = '0;
        exec_ent_we = 1'b0;
        exec_ent_wd = ent_rd_data;
        exec_occ_we = 1'b0;
        exec_occ_wd = occ_rd_data;
        if (r_err != grsp_pkg::ST_OK) begin
            // error word: status only, nothing changes
            rsp.status = r_err;
        end else if (r_req.req_type == grsp_pkg::REQ_ADD) begin
            exec_ent_we            = 1'b1;
            exec_ent_wd.tag        = r_req.object_tag;
            exec_ent_wd.state      = r_req.state_value;
            exec_ent_wd.format     = r_req.format_code;
            exec_ent_wd.generation = ent_rd_data.generation + 32'd1;  // wraps to zero
            exec_occ_we            = 1'b1;
            exec_occ_wd            = occ_rd_data | bit_mask;
            rsp.status             = grsp_pkg::ST_OK;
            rsp.out_slot           = slot_p1[8:0];
            rsp.out_generation     = ent_rd_data.generation + 32'd1;
            rsp.out_tag            = r_req.object_tag;
            rsp.state_before       = ent_rd_data.state;
            rsp.state_after        = r_req.state_value;
            rsp.out_format         = r_req.format_code;
        end else if (!handle_ok) begin
            rsp.status = grsp_pkg::ST_INVALID;
        end else begin
            rsp.status         = grsp_pkg::ST_OK;
            rsp.out_slot       = r_req.handle_slot;
            rsp.out_generation = ent_rd_data.generation;
            rsp.out_tag        = ent_rd_data.tag;
            rsp.state_before   = ent_rd_data.state;
            rsp.state_after    = ent_rd_data.state;
            rsp.out_format     = ent_rd_data.format;
            case (r_req.req_type)
                grsp_pkg::REQ_RELEASE: begin
                    // last reference gone: clear the entry, keep its generation
                    if (r_req.remaining_refs == 16'd0) begin
                        exec_ent_we        = 1'b1;
                        exec_ent_wd.tag    = '0;
                        exec_ent_wd.state  = '0;
                        exec_ent_wd.format = '0;
                        exec_occ_we        = 1'b1;
                        exec_occ_wd        = occ_rd_data & ~bit_mask;
                        rsp.state_after    = '0;
                        rsp.slot_freed     = 1'b1;
                    end
                end
                grsp_pkg::REQ_TRANSITION: begin
                    if (r_req.state_value != ent_rd_data.state) begin
                        exec_ent_we        = 1'b1;
                        exec_ent_wd.state  = r_req.state_value;
                        rsp.state_after    = r_req.state_value;
                        rsp.barrier_needed = 1'b1;
                    end
                end
                default: begin
                    // lookup leaves the entry as it is
                end
            endcase
        end
    end

    // write ports: clearing pass after reset, otherwise the execute step
    always_comb begin
        if (r_state == S_CLEAR) begin
            ent_we      = 1'b1;
            ent_wr_addr = r_cnt;
            ent_wd      = '0;
            occ_we      = 32'(r_cnt) < 32'(NUM_WORDS);
            occ_wr_addr = r_cnt[WORD_W-1:0];
            occ_wd      = '0;
        end else begin
            ent_we      = exec_go && exec_ent_we;
            ent_wr_addr = r_idx;
            ent_wd      = exec_ent_wd;
            occ_we      = exec_go && exec_occ_we;
            occ_wr_addr = r_word;
            occ_wd      = exec_occ_wd;
        end
    end

    // -------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + SLOT_W'(1);
                if (r_cnt == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (is_add && (n_err == grsp_pkg::ST_OK)) ? S_FIND : S_EXEC;
                end
            end
            S_FIND: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req  <= i_in_word;
            r_err  <= n_err;
            r_idx  <= slot_ext[SLOT_W-1:0];
            r_bit  <= slot_ext[grsp_pkg::OCC_BIT_W-1:0];
            r_word <= is_add ? occ_free_word : slot_ext[IDX_W-1:grsp_pkg::OCC_BIT_W];
        end else if (r_state == S_FIND) begin
            r_idx <= find_ext[SLOT_W-1:0];
            r_bit <= occ_free_bit;
        end
        if (exec_go) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/grsp_checker.sv
`timescale 1ns / 1ps

module grsp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input grsp_pkg::t_req   i_in_word,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input grsp_pkg::t_rsp   o_out_word
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word dropped or changed under stall");

    // one request in flight: input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request word taken while one is worked");

    // error words carry status only
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != grsp_pkg::ST_OK)) |->
        (o_out_word.out_slot == 9'd0 && o_out_word.out_generation == 32'd0 &&
         o_out_word.out_tag == 64'd0 && o_out_word.state_after == 32'd0 &&
         !o_out_word.barrier_needed && !o_out_word.slot_freed))
        else $error("error word with nonzero fields");

    // a barrier means a real state change and never comes with a release
    a_barrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.barrier_needed) |->
        (o_out_word.state_before != o_out_word.state_after && !o_out_word.slot_freed))
        else $error("barrier without state change");

    // a freed slot reports a cleared state
    a_freed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.slot_freed) |->
        (o_out_word.state_after == 32'd0 && o_out_word.status == grsp_pkg::ST_OK))
        else $error("freed slot with state left");

endmodule

bind generational_resource_slot_pool grsp_checker u_grsp_checker (.*);

### tb/generational_resource_slot_pool_tb.sv
`timescale 1ns / 1ps

module generational_resource_slot_pool_tb;

    import grsp_pkg::*;

    localparam int NUM_SLOTS = 256;
    localparam int N_WORDS   = 1550;

    // two copies of the slot table: one walked while the stimulus is built,
    // one advanced as request words are taken by the block
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    typedef struct packed {
        logic drain_first;
        t_req word;
    } t_pending;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_stall;
    t_req   i_in_word   = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_rsp   o_out_word;

    t_entry   pool_tbl [2][NUM_SLOTS];
    t_pending req_word_q[$];
    t_rsp     pool_rsp_q[$];

    int   mismatch_cnt = 0;
    int   rsp_seen     = 0;
    logic word_taken   = 1'b0;
    logic long_hold    = 1'b0;
    int   in_gap       = 0;
    int   in_calm      = 0;
    int   out_hold     = 0;
    int   out_calm     = 0;

    generational_resource_slot_pool #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // handle pool behaviour on one table copy: returns the response word and
    // updates the table the way the block must
    function automatic t_rsp pool_apply(int which, t_req rq);
        t_rsp r;
        int   idx;
        int   s;
        r   = '0;
        idx = -1;
        if (rq.req_type == REQ_ADD) begin
            // null tag rejected before any search
            if (rq.object_tag == '0) begin
                r.status = ST_NULL_TAG;
                return r;
            end
            for (s = NUM_SLOTS - 1; s >= 0; s--) begin
                if (pool_tbl[which][s].tag == '0)
                    idx = s;
            end
            if (idx < 0) begin
                r.status = ST_FULL;
                return r;
            end
            r.state_before                  = pool_tbl[which][idx].state;
            pool_tbl[which][idx].tag        = rq.object_tag;
            pool_tbl[which][idx].state      = rq.state_value;
            pool_tbl[which][idx].format     = rq.format_code;
            pool_tbl[which][idx].generation = pool_tbl[which][idx].generation + 32'd1;
            r.out_slot       = 9'(idx + 1);
            r.out_generation = pool_tbl[which][idx].generation;
            r.out_tag        = rq.object_tag;
            r.state_after    = rq.state_value;
            r.out_format     = rq.format_code;
            return r;
        end

        // handle check: slot in range, generation nonzero and matching, entry in use
        if (rq.handle_slot >= 9'd1 && rq.handle_slot <= 9'(NUM_SLOTS)) begin
            s = int'(rq.handle_slot) - 1;
            if (rq.handle_generation != '0
                    && rq.handle_generation == pool_tbl[which][s].generation
                    && pool_tbl[which][s].tag != '0)
                idx = s;
        end
        if (idx < 0) begin
            r.status = ST_INVALID;
            return r;
        end

        r.out_slot       = rq.handle_slot;
        r.out_generation = pool_tbl[which][idx].generation;
        r.out_tag        = pool_tbl[which][idx].tag;
        r.state_before   = pool_tbl[which][idx].state;
        r.out_format     = pool_tbl[which][idx].format;
        if (rq.req_type == REQ_RELEASE) begin
            // last reference gone: entry cleared, generation kept
            if (rq.remaining_refs == '0) begin
                pool_tbl[which][idx].tag    = '0;
                pool_tbl[which][idx].state  = '0;
                pool_tbl[which][idx].format = '0;
                r.slot_freed = 1'b1;
            end
        end else if (rq.req_type == REQ_TRANSITION) begin
            if (rq.state_value != pool_tbl[which][idx].state) begin
                pool_tbl[which][idx].state = rq.state_value;
                r.barrier_needed = 1'b1;
            end
        end
        r.state_after = pool_tbl[which][idx].state;
        return r;
    endfunction

    function automatic int live_count(int which);
        int n;
        n = 0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (pool_tbl[which][j].tag != '0)
                n++;
        end
        return n;
    endfunction

    // every field random, so fields the operation ignores still toggle
    function automatic t_req blank_req(t_req_type kind);
        t_req rq;
        rq.req_type          = kind;
        rq.handle_slot       = 9'($urandom);
        rq.handle_generation = $urandom;
        rq.object_tag        = {$urandom, $urandom};
        rq.state_value       = $urandom;
        rq.format_code       = 8'($urandom);
        rq.remaining_refs    = 16'($urandom);
        return rq;
    endfunction

    // idle length: mostly none or short, a few long, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_word(t_req rq, logic drain_first);
        t_rsp discard;
        req_word_q.push_back('{drain_first, rq});
        discard = pool_apply(PLAN, rq);
    endtask

    task automatic queue_op(t_req_type kind, int slot, logic [31:0] gen, logic [63:0] tag,
                            logic [31:0] stv, logic [7:0] fmt, logic [15:0] refs);
        t_req rq;
        rq.req_type          = kind;
        rq.handle_slot       = 9'(slot);
        rq.handle_generation = gen;
        rq.object_tag        = tag;
        rq.state_value       = stv;
        rq.format_code       = fmt;
        rq.remaining_refs    = refs;
        queue_word(rq, 1'b0);
    endtask

    // one random request: mostly well-formed handles taken from the planned table,
    // the rest broken handles of every kind
    task automatic queue_random(int add_pct, int rel_pct);
        t_req rq;
        int   pick;
        int   live;
        int   nth;
        int   s;
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
            rq = blank_req(REQ_ADD);
            if ($urandom_range(0, 29) == 0)
                rq.object_tag = '0;
            else if (rq.object_tag == '0)
                rq.object_tag = 64'd1;
        end else begin
            pick = $urandom_range(0, 99);
            rq   = blank_req(pick < rel_pct ? REQ_RELEASE
                             : (pick[0] ? REQ_LOOKUP : REQ_TRANSITION));
            live = live_count(PLAN);
            nth  = (live > 0) ? $urandom_range(0, live - 1) : -1;
            s    = 0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (pool_tbl[PLAN][j].tag != '0) begin
                    if (nth == 0)
                        s = j + 1;
                    nth--;
                end
            end
            if (s != 0 && $urandom_range(0, 99) < 75) begin
                rq.handle_slot       = 9'(s);
                rq.handle_generation = pool_tbl[PLAN][s-1].generation;
                if (rq.req_type == REQ_RELEASE && $urandom_range(0, 99) < 55)
                    rq.remaining_refs = '0;
                if (rq.req_type == REQ_TRANSITION && $urandom_range(0, 99) < 35)
                    rq.state_value = pool_tbl[PLAN][s-1].state;
            end else begin
                s = $urandom_range(1, NUM_SLOTS);
                case ($urandom_range(0, 4))
                    0: rq.handle_slot = '0;
                    1: rq.handle_slot = 9'($urandom_range(NUM_SLOTS + 1, 511));
                    2: begin
                        rq.handle_slot       = 9'(s);
                        rq.handle_generation = '0;
                    end
                    3: begin
                        rq.handle_slot       = 9'(s);
                        rq.handle_generation = pool_tbl[PLAN][s-1].generation
                                               + 32'($urandom_range(1, 3));
                    end
                    default: begin
                        // stored generation: stale when the slot is free
                        rq.handle_slot       = 9'(s);
                        rq.handle_generation = pool_tbl[PLAN][s-1].generation;
                    end
                endcase
            end
        end
        queue_word(rq, 1'b0);
    endtask

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("mismatch at %0t, result word %0d: %s", $time, rsp_seen, msg);
    endtask

    task automatic check_field(string fname, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", fname, got, want));
    endtask

    // stimulus build and end of run
    initial begin : run_test
        t_req rq;
        int   n;
        for (int w = 0; w < 2; w++) begin
            for (int j = 0; j < NUM_SLOTS; j++)
                pool_tbl[w][j] = '0;
        end

        // directed words from the empty pool
        queue_op(REQ_ADD, 0, 32'd0, 64'd0, 32'h1234, 8'h11, 16'd0);          // null tag
        queue_op(REQ_LOOKUP, 1, 32'd0, 64'd0, 32'd0, 8'd0, 16'd0);           // generation zero
        queue_op(REQ_ADD, 511, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
                 32'hffff_ffff, 8'hff, 16'hffff);                            // slot 1, all ones
        queue_op(REQ_ADD, 0, 32'd0, 64'd1, 32'd0, 8'd0, 16'd0);              // slot 2, minimum
        queue_op(REQ_LOOKUP, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_LOOKUP, 0, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);           // slot zero
        queue_op(REQ_LOOKUP, NUM_SLOTS + 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_LOOKUP, 511, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_LOOKUP, NUM_SLOTS, 32'd0, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_LOOKUP, 1, 32'd2, 64'd0, 32'd0, 8'd0, 16'd0);           // wrong generation
        queue_op(REQ_TRANSITION, 1, 32'hffff_ffff, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_TRANSITION, 1, 32'd1, 64'd0, 32'hffff_ffff, 8'd0, 16'd0); // same state
        queue_op(REQ_TRANSITION, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);        // barrier
        queue_op(REQ_RELEASE, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'hffff);       // still referenced
        queue_op(REQ_RELEASE, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd1);
        queue_op(REQ_RELEASE, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);          // freed
        queue_op(REQ_LOOKUP, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);           // free entry
        queue_op(REQ_RELEASE, 1, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_TRANSITION, 2, 32'd1, 64'd0, 32'ha5a5_a5a5, 8'd0, 16'd0);
        queue_op(REQ_ADD, 0, 32'd0, 64'h8000_0000_0000_0000, 32'h5a5a_5a5a,
                 8'h80, 16'd0);                                              // reuses slot 1
        queue_op(REQ_LOOKUP, 1, 32'd2, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_RELEASE, 2, 32'd1, 64'd0, 32'd0, 8'd0, 16'd0);
        queue_op(REQ_ADD, 0, 32'd0, 64'h0123_4567_89ab_cdef, 32'd7, 8'h3c, 16'd0);
        queue_op(REQ_TRANSITION, 2, 32'd2, 64'd0, 32'd7, 8'd0, 16'd0);

        // generation wrap would need 2^32 adds on one slot, out of reach here

        // mixed traffic, then fill the pool and try adds while full
        for (n = 0; n < 500; n++)
            queue_random(45, 30);
        while (live_count(PLAN) < NUM_SLOTS)
            queue_random(85, 20);
        for (n = 0; n < 8; n++) begin
            rq = blank_req(REQ_ADD);
            if (n == 3)
                rq.object_tag = '0;
            else if (rq.object_tag == '0)
                rq.object_tag = 64'd1;
            queue_word(rq, 1'b0);
        end
        // sender waits for every result before this one
        rq                   = blank_req(REQ_LOOKUP);
        rq.handle_slot       = 9'(NUM_SLOTS);
        rq.handle_generation = pool_tbl[PLAN][NUM_SLOTS-1].generation;
        queue_word(rq, 1'b1);
        // release-heavy mix so freed holes get refilled lowest first
        while (req_word_q.size() < N_WORDS)
            queue_random(35, 50);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_word_q.size() != 0 || i_in_valid || pool_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("generational_resource_slot_pool_tb: clean");
        else
            $display("generational_resource_slot_pool_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("generational_resource_slot_pool_tb: errors");
        $finish;
    end

    // receiver holds off for a long stretch once traffic is flowing
    initial begin : long_hold_stretch
        wait (rsp_seen >= 300);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (150) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // driver: a word stays put while stalled, a new one only after it is taken
    always @(negedge i_clk) begin : drive_words
        t_pending nxt;
        logic     offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            word_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (req_word_q.size() != 0
                         && !(req_word_q[0].drain_first && pool_rsp_q.size() != 0)) begin
                nxt = req_word_q.pop_front();
                i_in_word <= nxt.word;
                offer = 1'b1;
                in_gap = pick_gap(in_calm);
            end
            i_in_valid <= offer;
        end
    end

    // receiver stall: one free cycle, then a random hold; the long hold stalls throughout
    always @(negedge i_clk) begin : drive_stall
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= long_hold;
            out_hold = pick_gap(out_calm);
        end
    end

    // monitor: predict on every taken request word, check every taken result word
    always @(posedge i_clk) begin : watch_ports
        t_rsp want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pool_rsp_q.push_back(pool_apply(LIVE, i_in_word));
                word_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                rsp_seen++;
                if (pool_rsp_q.size() == 0) begin
                    report_mismatch("result word with nothing pending");
                end else begin
                    want = pool_rsp_q.pop_front();
                    check_field("status", o_out_word.status, want.status);
                    check_field("out_slot", o_out_word.out_slot, want.out_slot);
                    check_field("out_generation", o_out_word.out_generation,
                                want.out_generation);
                    check_field("out_tag", o_out_word.out_tag, want.out_tag);
                    check_field("state_before", o_out_word.state_before, want.state_before);
                    check_field("state_after", o_out_word.state_after, want.state_after);
                    check_field("out_format", o_out_word.out_format, want.out_format);
                    check_field("barrier_needed", o_out_word.barrier_needed,
                                want.barrier_needed);
                    check_field("slot_freed", o_out_word.slot_freed, want.slot_freed);
                end
            end
        end
    end

endmodule
